// File: rtl/fdgm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the forward-difference gradient magnitude block.
// No dependencies; imported by every module of the block.
package fdgm_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_W         = 13;
    localparam int ROW_W         = 12;
    localparam int MAX_HEIGHT    = 4096;
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int SUM_W         = 16;
    localparam int SQRT_STEPS    = 8;

    // configuration register indexes
    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    // one result on its way down the square-root cell row
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] grad_h;
        logic [PIX_W-1:0] grad_v;
        logic             from_final_row;
        logic             last_of_item;
        logic             frame_done;
        logic [SUM_W-1:0] sum;
        logic [PIX_W-1:0] root;
    } sqrt_stage_t;

endpackage

// File: rtl/fdgm_line_store.sv
`timescale 1ns / 1ps
// One-row pixel line store: one write port, two registered read ports, read-first.
// Depends on fdgm_pkg.
module fdgm_line_store import fdgm_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
    input  logic             aclk,
    input  logic             acc_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [PIX_W-1:0] rd_data_a,
    output logic [PIX_W-1:0] rd_data_b
);

    logic [PIX_W-1:0] mem [0:DEPTH-1];

    // port A reads the write address before it is overwritten
    always_ff @(posedge aclk) begin
        if (acc_en) begin
            rd_data_a     <= mem[wr_addr];
            rd_data_b     <= mem[rd_addr_b];
            mem[wr_addr]  <= wr_data;
        end
    end

endmodule

// File: rtl/fdgm_sqrt_cell.sv
`timescale 1ns / 1ps
// One cell of the square-root row: decides one root bit and passes the item on.
// Depends on fdgm_pkg.
module fdgm_sqrt_cell import fdgm_pkg::*; #(
    parameter int BIT_POS = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  sqrt_stage_t cell_in,
    output sqrt_stage_t cell_out
);

    localparam logic [PIX_W-1:0] BIT_MASK = PIX_W'(1 << BIT_POS);

    logic [PIX_W-1:0] trial;
    logic [SUM_W-1:0] trial_sq;
    sqrt_stage_t      cell_next;

    always_comb begin
        trial     = cell_in.root | BIT_MASK;
        trial_sq  = SUM_W'(trial) * SUM_W'(trial);
        cell_next = cell_in;
        if (trial_sq <= cell_in.sum) begin
            cell_next.root = trial;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_out.valid <= 1'b0;
        end else if (en) begin
            cell_out <= cell_next;
        end
    end

endmodule

// File: rtl/forward_difference_gradient_magnitude.sv
`timescale 1ns / 1ps
// Forward-difference gradient magnitude over a raster pixel stream.
// A pixel transfer reaches its results through the line store read, issue, square and
// eight square-root cells, in that order. A pixel with no result leaves s_tready high;
// a pixel with results holds the input until the single issue slot has issued them all.
// Reset (aresetn, synchronous): counters, held pixel and pipeline valids cleared;
// the line store is not cleared and needs no clearing pass.
module forward_difference_gradient_magnitude import fdgm_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] pixel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // [7:0] grad_horizontal, [15:8] grad_vertical,
                                        // [23:16] magnitude
    output logic [1:0]       m_tuser,   // [0] from_final_row, [1] last_of_item
    output logic             m_tlast,   // frame_done
    input  logic             cfg_wen,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int                CW      = $clog2(MAX_WIDTH);
    localparam logic [CW-1:0]     COL_MAX = CW'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX = ROW_W'(MAX_HEIGHT - 1);

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // configuration and frame position
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [CW-1:0]    col_reg, col_last;
    logic [ROW_W-1:0] row_reg, row_last;
    logic [PIX_W-1:0] held_reg;

    // item latched for result issue
    state_t           state_reg, state_next;
    logic [2:0]       pend_reg, pend_next;     // [0] row above, [1] held, [2] self
    logic [PIX_W-1:0] px_reg, held_prev_reg;
    logic             col_is_last_reg, frame_end_reg;

    logic             s_accept, en;
    logic             is_col_last, is_row_last, frame_end;
    logic [CW-1:0]    rd_addr_b;
    logic [PIX_W-1:0] above, right;

    sqrt_stage_t      inj_next, st0_reg, sq_reg, sq_next;
    sqrt_stage_t      cell_q [0:SQRT_STEPS];
    logic [2:0]       pend_left;
    logic [SUM_W-1:0] sq_h, sq_v;
    logic [SUM_W:0]   sum_full;

    // register values out of range are clamped
    always_comb begin
        if (width_reg == '0) begin
            col_last = '0;
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            col_last = COL_MAX;
        end else begin
            col_last = CW'(width_reg - 13'd1);
        end
        if (height_reg == '0) begin
            row_last = '0;
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            row_last = ROW_MAX;
        end else begin
            row_last = ROW_W'(height_reg - 13'd1);
        end
    end

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign en          = !m_tvalid || m_tready;
    assign is_col_last = (col_reg == col_last);
    assign is_row_last = (row_reg == row_last);
    assign frame_end   = is_col_last && is_row_last;
    assign rd_addr_b   = (col_reg == COL_MAX) ? col_reg : col_reg + CW'(1);

    fdgm_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .aclk      (aclk),
        .acc_en    (s_accept),
        .wr_addr   (col_reg),
        .wr_data   (s_tdata),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (above),
        .rd_data_b (right)
    );

    // frame position, held last-row pixel, configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
            col_reg    <= '0;
            row_reg    <= '0;
            held_reg   <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end else if (s_accept) begin
            if (is_col_last) begin
                col_reg <= '0;
                row_reg <= is_row_last ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
            if (frame_end) begin
                held_reg <= '0;
            end else if (is_row_last) begin
                held_reg <= s_tdata;
            end
        end
    end

    // pick the next pending result, in output order
    always_comb begin
        inj_next                = '0;
        inj_next.valid          = (state_reg == ST_EMIT);
        pend_left               = pend_reg;
        if (pend_reg[0]) begin
            inj_next.grad_h     = col_is_last_reg ? above : absdiff(right, above);
            inj_next.grad_v     = absdiff(px_reg, above);
            pend_left[0]        = 1'b0;
        end else if (pend_reg[1]) begin
            inj_next.grad_h     = absdiff(px_reg, held_prev_reg);
            inj_next.grad_v     = held_prev_reg;
            inj_next.from_final_row = 1'b1;
            pend_left[1]        = 1'b0;
        end else begin
            inj_next.grad_h     = px_reg;
            inj_next.grad_v     = px_reg;
            inj_next.from_final_row = 1'b1;
            pend_left[2]        = 1'b0;
        end
        inj_next.last_of_item   = (pend_left == '0);
        inj_next.frame_done     = (pend_left == '0) && frame_end_reg;
    end

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    pend_next = {is_row_last && is_col_last,
                                 is_row_last && (col_reg != '0),
                                 row_reg != '0};
                    state_next = (pend_next != '0) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (en) begin
                    pend_next  = pend_left;
                    state_next = (pend_left == '0) ? ST_IDLE : ST_EMIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
        if (s_accept) begin
            px_reg          <= s_tdata;
            held_prev_reg   <= held_reg;
            col_is_last_reg <= is_col_last;
            frame_end_reg   <= frame_end;
        end
    end

    // issue slot and square stage; whole pipe stalls together on output backpressure
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_reg.valid <= 1'b0;
        end else if (en) begin
            st0_reg <= inj_next;
        end
    end

    assign sq_h     = SUM_W'(st0_reg.grad_h) * SUM_W'(st0_reg.grad_h);
    assign sq_v     = SUM_W'(st0_reg.grad_v) * SUM_W'(st0_reg.grad_v);
    assign sum_full = {1'b0, sq_h} + {1'b0, sq_v};

    always_comb begin
        sq_next      = st0_reg;
        // sums of 65536 and up saturate: sqrt(65535) floors to 255
        sq_next.sum  = sum_full[SUM_W] ? '1 : sum_full[SUM_W-1:0];
        sq_next.root = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg.valid <= 1'b0;
        end else if (en) begin
            sq_reg <= sq_next;
        end
    end

    assign cell_q[0] = sq_reg;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_cell
        fdgm_sqrt_cell #(
            .BIT_POS (SQRT_STEPS - 1 - i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (cell_q[i]),
            .cell_out (cell_q[i+1])
        );
    end

    assign m_tvalid = cell_q[SQRT_STEPS].valid;
    assign m_tdata  = {cell_q[SQRT_STEPS].root, cell_q[SQRT_STEPS].grad_v,
                       cell_q[SQRT_STEPS].grad_h};
    assign m_tuser  = {cell_q[SQRT_STEPS].last_of_item, cell_q[SQRT_STEPS].from_final_row};
    assign m_tlast  = cell_q[SQRT_STEPS].frame_done;

`ifndef SYNTHESIS
    a_no_accept_while_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != '0) |-> !s_tready)
        else $error("input taken while results still pending");

    a_frame_done_closes_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[1])
        else $error("frame end on a result that is not the last of its pixel");

    a_position_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= col_last) && (row_reg <= row_last))
        else $error("frame position outside configured size");

    a_emit_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (pend_reg != '0))
        else $error("issue state with nothing to issue");
`endif

endmodule

// File: tb/sv/forward_difference_gradient_magnitude_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for forward_difference_gradient_magnitude: streams pixel frames,
// predicts every gradient result in-bench and compares it in order with the m_ channel.
// Depends on fdgm_pkg and the RTL of the block only.
module forward_difference_gradient_magnitude_tb;
    import fdgm_pkg::*;

    localparam int DRAIN_CYCLES = 40;    // well past the depth of the pipeline
    localparam int LONG_HOLD    = 400;
    localparam int TB_AW        = $clog2(DEF_MAX_WIDTH);

    typedef struct packed {
        logic [7:0] grad_h;
        logic [7:0] grad_v;
        logic [7:0] mag;
        logic       final_row;
        logic       item_end;
        logic       frame_end;
    } grad_t;

    typedef enum int {RX_STREAM, RX_JITTER, RX_CHOKE} rx_mode_t;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [23:0]      m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;
    logic             cfg_wen   = 1'b0;
    logic [0:0]       cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0] cfg_wdata = '0;

    forward_difference_gradient_magnitude uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // gradient predictor state
    grad_t            pending_grads[$];
    logic [7:0]       line_buf [0:DEF_MAX_WIDTH-1];
    int unsigned      col_pos, row_pos;
    logic [7:0]       held_px;
    logic [CFG_W-1:0] width_reg, height_reg;
    int               mismatch_count = 0;

    // sender / receiver control
    int       burst_left = 0;
    bit       steady_send = 1'b0;
    int       hold_req = 0, hold_seen = 0, hold_left = 0;
    int       stall_left = 0, mode_left = 0;
    rx_mode_t rx_mode = RX_STREAM;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
        if (v == 0) return 1;
        if (32'(v) > lim) return lim;
        return 32'(v);
    endfunction

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // floor(sqrt(gh^2 + gv^2)), saturated at 255
    function automatic grad_t make_grad(input logic [7:0] gh, input logic [7:0] gv,
                                        input logic fr);
        grad_t g;
        int unsigned sq, root, trial;
        sq = 32'(gh) * 32'(gh) + 32'(gv) * 32'(gv);
        root = 0;
        if (sq >= 65536) root = 255;
        else begin
            for (int b = 7; b >= 0; b--) begin
                trial = root | (1 << b);
                if (trial * trial <= sq) root = trial;
            end
        end
        g.grad_h    = gh;
        g.grad_v    = gv;
        g.mag       = root[7:0];
        g.final_row = fr;
        g.item_end  = 1'b0;
        g.frame_end = 1'b0;
        return g;
    endfunction

    task automatic track_pixel(input logic [7:0] px);
        int unsigned w, h, c, r;
        bit          last_px;
        logic [7:0]  above;
        grad_t       res[$];
        grad_t       tail;
        w = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;
        last_px = (r == h - 1) && (c == w - 1);
        // result for the pixel above comes first
        if (r >= 1) begin
            above = line_buf[TB_AW'(c)];
            res.push_back(make_grad((c == w - 1) ? above
                                                 : absdiff(line_buf[TB_AW'(c + 1)], above),
                                    absdiff(px, above), 1'b0));
        end
        // last row: left neighbor goes out one pixel late, last column its own result
        if (r == h - 1) begin
            if (c >= 1) res.push_back(make_grad(absdiff(px, held_px), held_px, 1'b1));
            if (c == w - 1) res.push_back(make_grad(px, px, 1'b1));
            held_px = px;
        end
        line_buf[TB_AW'(c)] = px;
        if (res.size() > 0) begin
            tail = res.pop_back();
            tail.item_end  = 1'b1;
            tail.frame_end = last_px;
            res.push_back(tail);
        end
        foreach (res[i]) pending_grads.push_back(res[i]);
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
        if (last_px) held_px = '0;
    endtask

    task automatic check_grad();
        grad_t want, got;
        got.grad_h    = m_tdata[7:0];
        got.grad_v    = m_tdata[15:8];
        got.mag       = m_tdata[23:16];
        got.final_row = m_tuser[0];
        got.item_end  = m_tuser[1];
        got.frame_end = m_tlast;
        if (pending_grads.size() == 0) begin
            if (mismatch_count < 10)
                $display("unexpected result gh=%0d gv=%0d mag=%0d fr=%0b ie=%0b fe=%0b",
                         got.grad_h, got.grad_v, got.mag, got.final_row, got.item_end,
                         got.frame_end);
            mismatch_count++;
        end else begin
            want = pending_grads.pop_front();
            if (got !== want) begin
                if (mismatch_count < 10) begin
                    $display("mismatch: exp gh=%0d gv=%0d mag=%0d fr=%0b ie=%0b fe=%0b",
                             want.grad_h, want.grad_v, want.mag, want.final_row,
                             want.item_end, want.frame_end);
                    $display("          act gh=%0d gv=%0d mag=%0d fr=%0b ie=%0b fe=%0b",
                             got.grad_h, got.grad_v, got.mag, got.final_row,
                             got.item_end, got.frame_end);
                end
                mismatch_count++;
            end
        end
    endtask

    // monitor: config writes, pixel transfers and result transfers, all seen at the edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            col_pos    = 0;
            row_pos    = 0;
            held_px    = '0;
            width_reg  = 13'd640;
            height_reg = 13'd480;
        end else begin
            if (cfg_wen) begin
                if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_wdata;
                else height_reg = cfg_wdata;
                col_pos = 0;
                row_pos = 0;
                held_px = '0;
            end
            if (s_tvalid && s_tready) track_pixel(s_tdata);
            if (m_tvalid && m_tready) check_grad();
        end
    end

    // receiver: stall pattern switches mode now and then; a long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(64, 256);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                case (rx_mode)
                    RX_JITTER: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
                    RX_CHOKE:  if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 10);
                    default: ;
                endcase
            end
        end
    end

    task automatic send_pixel(input logic [7:0] px);
        int gap;
        if (burst_left == 0 && !steady_send) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [7:0] rand_pixel();
        if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // stop offering, wait for every expected result, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_grads.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // default geometry after reset: the start of the first row gives no result
    task automatic test_reset_geometry();
        repeat (10) send_pixel(rand_pixel());
        drain();
    endtask

    task automatic test_directed_patterns();
        logic [7:0] grid [12] = '{8'h00, 8'hFF, 8'h00, 8'hFF,
                                  8'hFF, 8'h00, 8'hFF, 8'h00,
                                  8'h00, 8'h00, 8'hFF, 8'hFF};
        set_frame(13'd4, 13'd3);
        foreach (grid[i]) send_pixel(grid[i]);
        drain();
        // single pixel frames, also via zero-valued registers
        set_frame(13'd1, 13'd1);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        drain();
        set_frame(13'd0, 13'd0);
        send_pixel(8'hFF);
        send_pixel(8'h80);
        send_pixel(8'h01);
        drain();
        // single row frame
        set_frame(13'd3, 13'd1);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h80);
        drain();
    endtask

    task automatic test_random_frames();
        int sent, n;
        int unsigned w, h;
        sent = 0;
        while (sent < 36) begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
            h = $urandom_range(0, 6);
            set_frame(CFG_W'(w), CFG_W'(h));
            n = clamp_dim(CFG_W'(w), DEF_MAX_WIDTH) * clamp_dim(CFG_W'(h), MAX_HEIGHT)
                * $urandom_range(1, 2);
            // now and then a frame broken off by the next register write
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            if (sent + n > 36) n = 36 - sent;
            repeat (n) send_pixel(rand_pixel());
            sent += n;
            drain();
        end
    endtask

    // receiver holds off while the sender keeps offering: input must stall
    task automatic test_backpressure();
        set_frame(13'd6, 13'd2);
        steady_send = 1'b1;
        hold_req++;
        repeat (24) send_pixel(rand_pixel());
        steady_send = 1'b0;
        drain();
    endtask

    // register limits: widths and heights at and above the largest frame
    task automatic test_max_geometry();
        set_frame(13'd4096, 13'd1);
        repeat (8) send_pixel(rand_pixel());
        drain();
        set_frame(13'd8191, 13'd1);
        repeat (8) send_pixel(rand_pixel());
        drain();
        set_frame(13'd1, 13'd4096);
        repeat (8) send_pixel(rand_pixel());
        drain();
        set_frame(13'd1, 13'd8191);
        repeat (8) send_pixel(rand_pixel());
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_geometry();
        test_directed_patterns();
        test_random_frames();
        test_backpressure();
        test_max_geometry();
        drain();
        if (mismatch_count == 0 && pending_grads.size() == 0) begin
            $display("forward_difference_gradient_magnitude_tb passed");
        end else begin
            $display("forward_difference_gradient_magnitude_tb failed");
        end
        $finish;
    end

    // 200 us: several times the slowest legal run
    initial begin
        #200_000;
        $display("forward_difference_gradient_magnitude_tb failed");
        $finish;
    end

endmodule

// File: forward_difference_gradient_magnitude.f
rtl/fdgm_pkg.sv
rtl/fdgm_line_store.sv
rtl/fdgm_sqrt_cell.sv
rtl/forward_difference_gradient_magnitude.sv
tb/sv/forward_difference_gradient_magnitude_tb.sv
